// ===== rtl/lgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgrs_pkg
// shared constants and types for the life generation row stencil
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 1024;

  localparam int ROW_W      = MAX_COLS;
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 7;
  localparam int ROWNUM_W   = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // neighbor counts of the b3/s23 rule
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;
  localparam int NBR_W         = 4;

  // result queue, depth is a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

  localparam logic [ROWS_W-1:0] NUM_ROWS_RESET = ROWS_W'(80);
  localparam logic [COLS_W-1:0] NUM_COLS_RESET = COLS_W'(60);
  localparam logic [ROWS_W-1:0] MIN_ROWS       = ROWS_W'(2);
  localparam logic [ROWS_W-1:0] MAX_ROWS_V     = ROWS_W'(MAX_ROWS);
  localparam logic [COLS_W-1:0] MIN_COLS_V     = COLS_W'(1);
  localparam logic [COLS_W-1:0] MAX_COLS_V     = COLS_W'(MAX_COLS);

  typedef struct packed {
    logic [ROW_W-1:0]    cells;
    logic [ROWNUM_W-1:0] row_number;
    logic                final_row;
  } result_t;

endpackage

// ===== rtl/lgrs_lane.sv =====
// ----------------------------------------------------------------------------
// lgrs_lane
// one column of the stencil: counts the eight neighbors and applies b3/s23
// ----------------------------------------------------------------------------
module lgrs_lane
  import lgrs_pkg::*;
(
  input  logic [2:0] above,
  input  logic [2:0] cur,
  input  logic [2:0] below,
  input  logic       en,
  output logic       alive_next
);

  logic [NBR_W-1:0] nbr_count;

  always_comb begin
    nbr_count = NBR_W'(above[0]) + NBR_W'(above[1]) + NBR_W'(above[2])
              + NBR_W'(cur[0]) + NBR_W'(cur[2])
              + NBR_W'(below[0]) + NBR_W'(below[1]) + NBR_W'(below[2]);
    alive_next = en && ((nbr_count == NBR_W'(BIRTH_COUNT))
                 || (cur[1] && nbr_count == NBR_W'(SURVIVE_COUNT)));
  end

endmodule

// ===== rtl/lgrs_row_unit.sv =====
// ----------------------------------------------------------------------------
// lgrs_row_unit
// one lane per column side by side, lane bits merged into the next row
// ----------------------------------------------------------------------------
module lgrs_row_unit
  import lgrs_pkg::*;
(
  input  logic [ROW_W-1:0] above,
  input  logic [ROW_W-1:0] cur,
  input  logic [ROW_W-1:0] below,
  input  logic [ROW_W-1:0] col_mask,
  output logic [ROW_W-1:0] next_row
);

  // one dead cell on each side of the grid
  logic [ROW_W+1:0] above_pad;
  logic [ROW_W+1:0] cur_pad;
  logic [ROW_W+1:0] below_pad;
  logic [ROW_W-1:0] lane_bits;

  assign above_pad = {1'b0, above, 1'b0};
  assign cur_pad   = {1'b0, cur, 1'b0};
  assign below_pad = {1'b0, below, 1'b0};

  for (genvar j = 0; j < ROW_W; j++) begin : g_lane
    lgrs_lane u_lane (
      .above      (above_pad[j+2:j]),
      .cur        (cur_pad[j+2:j]),
      .below      (below_pad[j+2:j]),
      .en         (col_mask[j]),
      .alive_next (lane_bits[j])
    );
  end

  assign next_row = lane_bits & col_mask;

endmodule

// ===== rtl/lgrs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lgrs_out_fifo
// small result queue, takes up to two items a cycle and hands out one
// ----------------------------------------------------------------------------
module lgrs_out_fifo
  import lgrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_first,
  input  logic    push_second,
  input  result_t first_item,
  input  result_t second_item,
  input  logic    pop,
  output result_t head_item,
  output logic    head_valid,
  output logic    room_for_two
);

  result_t          entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // the second item always follows a first one in the same cycle
  always_ff @(posedge clk) begin
    if (push_first) begin
      entries[wr_ptr] <= first_item;
    end
    if (push_second) begin
      entries[wr_ptr + PTR_W'(1)] <= second_item;
    end
  end

  always_comb begin
    count_next = count + CNT_W'(push_first) + CNT_W'(push_second) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_first) + PTR_W'(push_second);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign head_item    = entries[rd_ptr];
  assign head_valid   = (count != '0);
  assign room_for_two = (count <= CNT_W'(FIFO_DEPTH - 2));

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push_second |-> push_first)
    else $error("second result pushed without a first");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_first |-> room_for_two)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("result queue underflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== rtl/life_generation_row_stencil.sv =====
// ----------------------------------------------------------------------------
// life_generation_row_stencil
// one b3/s23 generation over a bounded grid, one row per item
// ----------------------------------------------------------------------------
// each result is registered in the result queue as the row causing it is taken
// throughput: one row per cycle while in_ready is high; the last row of a grid
//   yields two results, handed out in turn by the single read port of the queue
// in_ready drops while the result queue has fewer than two free entries
// reset (rst, synchronous): row history and row count cleared, queue emptied,
//   num_rows back to 80 and num_cols back to 60
// ----------------------------------------------------------------------------
module life_generation_row_stencil
  import lgrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ROW_W-1:0]      row_cells,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_W-1:0]      next_row_cells,
  output logic [ROWNUM_W-1:0]   row_number,
  output logic                  final_row
);

  logic [ROWS_W-1:0] num_rows;
  logic [COLS_W-1:0] num_cols;
  logic [ROW_W-1:0]  older_row;
  logic [ROW_W-1:0]  middle_row;
  logic [ROWS_W-1:0] rows_received;

  logic [ROWS_W-1:0] eff_rows;
  logic [ROWS_W-1:0] last_index;
  logic [COLS_W-1:0] eff_cols;
  logic [ROW_W-1:0]  col_mask;
  logic [ROW_W-1:0]  row_in;
  logic [ROW_W-1:0]  older_m;
  logic [ROW_W-1:0]  middle_m;
  logic [ROW_W-1:0]  mid_next;
  logic [ROW_W-1:0]  last_next;
  logic              accept;
  logic              is_last;
  logic              room_for_two;
  logic              head_valid;
  result_t           first_item;
  result_t           second_item;
  result_t           head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= NUM_ROWS_RESET;
      num_cols <= NUM_COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_data;
        CFG_NUM_COLS: num_cols <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the configured sizes into range
  always_comb begin
    eff_rows = num_rows;
    if (num_rows < MIN_ROWS) begin
      eff_rows = MIN_ROWS;
    end else if (num_rows > MAX_ROWS_V) begin
      eff_rows = MAX_ROWS_V;
    end
    eff_cols = num_cols;
    if (num_cols < MIN_COLS_V) begin
      eff_cols = MIN_COLS_V;
    end else if (num_cols > MAX_COLS_V) begin
      eff_cols = MAX_COLS_V;
    end
    for (int j = 0; j < ROW_W; j++) begin
      col_mask[j] = (COLS_W'(j) < eff_cols);
    end
  end

  assign last_index = eff_rows - ROWS_W'(1);
  assign is_last    = (rows_received >= last_index);
  assign accept     = in_valid && in_ready;
  assign in_ready   = room_for_two;

  // stored rows are masked again in case the column count changed
  assign row_in   = row_cells & col_mask;
  assign older_m  = older_row & col_mask;
  assign middle_m = middle_row & col_mask;

  lgrs_row_unit u_mid_row (
    .above    (older_m),
    .cur      (middle_m),
    .below    (row_in),
    .col_mask (col_mask),
    .next_row (mid_next)
  );

  // last row of the grid, dead row below it
  lgrs_row_unit u_last_row (
    .above    (middle_m),
    .cur      (row_in),
    .below    ('0),
    .col_mask (col_mask),
    .next_row (last_next)
  );

  always_comb begin
    first_item.cells       = mid_next;
    first_item.row_number  = ROWNUM_W'(rows_received - ROWS_W'(1));
    first_item.final_row   = 1'b0;
    second_item.cells      = last_next;
    second_item.row_number = rows_received[ROWNUM_W-1:0];
    second_item.final_row  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_row     <= '0;
      middle_row    <= '0;
      rows_received <= '0;
    end else if (accept) begin
      if (is_last) begin
        older_row     <= '0;
        middle_row    <= '0;
        rows_received <= '0;
      end else begin
        older_row     <= middle_m;
        middle_row    <= row_in;
        rows_received <= rows_received + ROWS_W'(1);
      end
    end
  end

  lgrs_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_first   (accept && (rows_received != '0)),
    .push_second  (accept && is_last),
    .first_item   (first_item),
    .second_item  (second_item),
    .pop          (head_valid && out_ready),
    .head_item    (head_item),
    .head_valid   (head_valid),
    .room_for_two (room_for_two)
  );

  assign out_valid      = head_valid;
  assign next_row_cells = head_item.cells;
  assign row_number     = head_item.row_number;
  assign final_row      = head_item.final_row;

`ifndef SYNTHESIS
  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> (rows_received == '0))
    else $error("row count not cleared after the last row");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    rows_received < MAX_ROWS_V)
    else $error("row count beyond the grid");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(next_row_cells)
      && $stable(row_number) && $stable(final_row)))
    else $error("waiting result changed before it was taken");
`endif

endmodule
